// ===== rtl/iir_direct_form_one_filter_macros.svh =====
// shared assertion macros for the filter
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// same-cycle implication
`define IIRDF1_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define IIRDF1_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/iirdf1_pkg.sv =====
`timescale 1ns / 1ps

package iirdf1_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;
  localparam int HIST_DEPTH = 3;
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [Q_W-1:0]    SAT_MAX    = Q_W'(32767);
  localparam logic signed [Q_W-1:0]    SAT_MIN    = -Q_W'(32768);
  localparam logic signed [COEF_W-1:0] B0_RESET   = COEF_W'(16384);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_B0 = 3'd0;
  localparam reg_idx_t REG_B1 = 3'd1;
  localparam reg_idx_t REG_B2 = 3'd2;
  localparam reg_idx_t REG_B3 = 3'd3;
  localparam reg_idx_t REG_A1 = 3'd4;
  localparam reg_idx_t REG_A2 = 3'd5;
  localparam reg_idx_t REG_A3 = 3'd6;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    reg_idx_t idx;
    logic     first;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/iirdf1_regs.sv =====
`timescale 1ns / 1ps

module iirdf1_regs
  import iirdf1_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output coef_t             coefs [NUM_REGS]
);

  logic     wr;
  reg_idx_t widx;
  coef_t    wval;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[ADDR_W-1:2];
  assign wval   = pwdata[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[REG_B0] <= B0_RESET;
      coefs[REG_B1] <= '0;
      coefs[REG_B2] <= '0;
      coefs[REG_B3] <= '0;
      coefs[REG_A1] <= '0;
      coefs[REG_A2] <= '0;
      coefs[REG_A3] <= '0;
    end else if (wr) begin
      case (widx)
        REG_B0: coefs[REG_B0] <= wval;
        REG_B1: coefs[REG_B1] <= wval;
        REG_B2: coefs[REG_B2] <= wval;
        REG_B3: coefs[REG_B3] <= wval;
        REG_A1: coefs[REG_A1] <= wval;
        REG_A2: coefs[REG_A2] <= wval;
        REG_A3: coefs[REG_A3] <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_B0:  prdata = DATA_W'(coefs[REG_B0]);
      REG_B1:  prdata = DATA_W'(coefs[REG_B1]);
      REG_B2:  prdata = DATA_W'(coefs[REG_B2]);
      REG_B3:  prdata = DATA_W'(coefs[REG_B3]);
      REG_A1:  prdata = DATA_W'(coefs[REG_A1]);
      REG_A2:  prdata = DATA_W'(coefs[REG_A2]);
      REG_A3:  prdata = DATA_W'(coefs[REG_A3]);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== rtl/iirdf1_ctrl.sv =====
`timescale 1ns / 1ps

module iirdf1_ctrl
  import iirdf1_pkg::*;
#(
  parameter int NUM_FF_TAPS = 4,
  parameter int NUM_FB_TAPS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int NSTEP = NUM_FF_TAPS + NUM_FB_TAPS - 1;

  state_t   state, state_next;
  reg_idx_t cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          // first tap multiplies straight off the input beat
          cmd.load   = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.idx    = REG_B0;
          cmd.first  = 1'b1;
          cnt_next   = reg_idx_t'(1);
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mul_en = 1'b1;
        if (cnt < reg_idx_t'(NUM_FF_TAPS)) begin
          cmd.idx = cnt;
        end else begin
          cmd.idx = cnt + reg_idx_t'(int'(REG_A1) - NUM_FF_TAPS);
        end
        if (cnt == reg_idx_t'(NSTEP - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + reg_idx_t'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/iirdf1_dp.sv =====
`timescale 1ns / 1ps

module iirdf1_dp
  import iirdf1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sample_t    sample_in,
  input  coef_t      coefs [NUM_REGS],
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output sample_t    sample_out,
  output logic       clipped
);

  sample_t x_cur;
  sample_t x_hist [HIST_DEPTH];
  sample_t y_hist [HIST_DEPTH];

  sample_t                   opnd;
  coef_t                     coef_sel;
  logic signed [PROD_W-1:0]  mult;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_sub;
  logic                      prod_first;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [Q_W-1:0]     q;
  sample_t                   y_sat;
  logic                      clip;

  // operand and coefficient for the tap being issued
  always_comb begin
    case (cmd.idx)
      REG_B0:  opnd = sample_in;
      REG_B1:  opnd = x_hist[0];
      REG_B2:  opnd = x_hist[1];
      REG_B3:  opnd = x_hist[2];
      REG_A1:  opnd = y_hist[0];
      REG_A2:  opnd = y_hist[1];
      REG_A3:  opnd = y_hist[2];
      default: opnd = '0;
    endcase
  end

  assign coef_sel = coefs[cmd.idx];
  assign mult     = coef_sel * opnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod       <= mult;
      prod_sub   <= (cmd.idx >= REG_A1);
      prod_first <= cmd.first;
    end
    if (cmd.load) begin
      x_cur <= sample_in;
    end
  end

  assign acc_base = prod_first ? '0 : acc;

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      if (prod_sub) begin
        acc <= acc_base - ACC_W'(prod);
      end else begin
        acc <= acc_base + ACC_W'(prod);
      end
    end
  end

  // round half up, then saturate
  assign acc_rnd = acc + ROUND_HALF;
  assign q       = acc_rnd[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if (q > SAT_MAX) begin
      y_sat = SAT_MAX[SAMPLE_W-1:0];
      clip  = 1'b1;
    end else if (q < SAT_MIN) begin
      y_sat = SAT_MIN[SAMPLE_W-1:0];
      clip  = 1'b1;
    end else begin
      y_sat = q[SAMPLE_W-1:0];
      clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        x_hist[i] <= x_hist[i-1];
        y_hist[i] <= y_hist[i-1];
      end
      x_hist[0] <= x_cur;
      y_hist[0] <= y_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out <= y_sat;
      clipped    <= clip;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/iir_direct_form_one_filter.sv =====
`timescale 1ns / 1ps
// Direct form I IIR filter, Q1.15 samples, Q4.14 coefficients.
// Input stream: s_tvalid/s_tready/s_tdata carries one sample per beat.
// Output stream: m_tvalid/m_tready/m_tdata carries the filtered sample,
// m_tuser flags a saturated result. One output beat per input beat, in order.
// Coefficients b0..b3, a1..a3 sit on the APB port at byte addresses 0..24;
// write them only while no sample is in flight.
// One shared 18x16 multiplier walks the taps, one per cycle, into a 36-bit
// accumulator. With T = NUM_FF_TAPS + NUM_FB_TAPS - 1 taps (seven at the
// default), the sum passes a drain and a finish state before it is committed,
// and a new input beat is taken only after the last result is committed.
// The output sits in its own register, so the next sample is accepted while
// a result waits; if the receiver still stalls when the next result is
// ready, the block holds that result and stops taking input.
// Reset clears the sample histories and the pipeline and loads b0 = 1.0,
// all other coefficients 0.

`include "iir_direct_form_one_filter_macros.svh"

module iir_direct_form_one_filter
  import iirdf1_pkg::*;
#(
  parameter int NUM_FF_TAPS = 4,
  parameter int NUM_FB_TAPS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] sample_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [15:0] sample_out
  output logic [0:0]        m_tuser,   // [0] clipped
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  coef_t      coefs [NUM_REGS];
  dp_cmd_t    cmd;
  dp_status_t status;
  sample_t    sample_out;
  logic       clipped;

  iirdf1_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  iirdf1_ctrl #(
    .NUM_FF_TAPS (NUM_FF_TAPS),
    .NUM_FB_TAPS (NUM_FB_TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  iirdf1_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (s_tdata),
    .coefs      (coefs),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  assign m_tdata    = sample_out;
  assign m_tuser[0] = clipped;

  `IIRDF1_ASSERT_NOW(a_commit_free, cmd.commit, (!m_tvalid || m_tready), "result overwrote a waiting beat")
  `IIRDF1_ASSERT_NEXT(a_one_in_flight, (s_tvalid && s_tready), !s_tready, "second sample taken while busy")
  `IIRDF1_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid, "committed result not presented")
  `IIRDF1_ASSERT_NOW(a_no_mul_idle, (s_tready && !s_tvalid), !cmd.mul_en, "multiply issued while idle")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import iirdf1_pkg::*;
;

  localparam int REG_SPARE    = NUM_REGS;
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_ITEMS   = 120;
  localparam logic [15:0] CORNER_SAMPLES [7] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                                                 16'hffff, 16'h5555, 16'haaaa};

  typedef enum int {MIX_FULL, MIX_MILD, MIX_CORNER} coef_mix_t;

  typedef struct {
    sample_t sample;
    logic    clip;
  } filtered_t;

  class filter_scoreboard;
    coef_t     coef [NUM_REGS];
    sample_t   x_hist [HIST_DEPTH];
    sample_t   y_hist [HIST_DEPTH];
    filtered_t expected_out [$];
    int        errors;
    int        samples_in;
    int        outputs_seen;
    int        clipped_seen;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_B0] = B0_RESET;
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      errors = 0;
      samples_in = 0;
      outputs_seen = 0;
      clipped_seen = 0;
    endfunction

    function void write_coef(int idx, logic [DATA_W-1:0] value);
      if (idx < NUM_REGS) coef[idx] = coef_t'(value[COEF_W-1:0]);
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      sample_t   x;
      longint    acc;
      longint    y;
      filtered_t e;
      x = sample_t'(raw);
      samples_in++;
      acc = longint'(coef[REG_B0]) * longint'(x);
      for (int k = 1; k <= HIST_DEPTH; k++) begin
        acc += longint'(coef[REG_B0 + k]) * longint'(x_hist[k-1]);
        acc -= longint'(coef[REG_B3 + k]) * longint'(y_hist[k-1]);
      end
      y = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      e.clip = 1'b0;
      if (y > longint'(SAT_MAX)) begin
        y = longint'(SAT_MAX);
        e.clip = 1'b1;
      end else if (y < longint'(SAT_MIN)) begin
        y = longint'(SAT_MIN);
        e.clip = 1'b1;
      end
      e.sample = sample_t'(y);
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
        x_hist[k] = x_hist[k-1];
        y_hist[k] = y_hist[k-1];
      end
      x_hist[0] = x;
      y_hist[0] = e.sample;
      expected_out.push_back(e);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] data, logic clip);
      filtered_t e;
      outputs_seen++;
      if (clip) clipped_seen++;
      if (expected_out.size() == 0) begin
        note_error($sformatf("output %h clipped %b with none expected", data, clip));
        return;
      end
      e = expected_out.pop_front();
      if (data !== e.sample)
        note_error($sformatf("sample_out expected %h actual %h", e.sample, data));
      if (clip !== e.clip)
        note_error($sformatf("clipped expected %b actual %b", e.clip, clip));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;    // [15:0] sample_in
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;         // [15:0] sample_out
  logic [0:0]        m_tuser;         // [0] clipped
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  filter_scoreboard sb;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  iir_direct_form_one_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitors
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.take_sample(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser[0]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sink_pacing
    int n;
    forever begin
      @(posedge clk);
      if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        n = $urandom_range(1, 15);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic write_coef(input int idx, input logic [COEF_W-1:0] value);
    logic [DATA_W-1:0] wdata;
    wdata = $urandom();
    wdata[COEF_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_coef(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all_coefs(input logic [COEF_W-1:0] value);
    for (int i = REG_B0; i <= REG_A3; i++) write_coef(i, value);
    settings_used++;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(coef_mix_t mix);
    logic [COEF_W-1:0] c;
    case (mix)
      MIX_FULL: c = COEF_W'($urandom());
      MIX_MILD: c = COEF_W'(int'($urandom_range(0, 16383)) - 8192);
      default: begin
        case ($urandom_range(4))
          0: c = COEF_W'(131071);
          1: c = COEF_W'(-131072);
          2: c = COEF_W'(16384);
          3: c = COEF_W'(-16384);
          default: c = '0;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return CORNER_SAMPLES[$urandom_range(6)];
    if (r < 30) return 16'(int'($urandom_range(0, 511)) - 256);
    return 16'($urandom());
  endfunction

  // leaves s_tvalid high so back-to-back beats need no extra edge
  task automatic send_sample(input logic [15:0] value);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin : stimulus
    coef_mix_t mix;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients pass samples straight through
    settings_used = 1;
    src_gap_pct = 20;
    sink_stall_pct = 20;
    foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i]);
    drain();

    // write past the last register must leave the filter untouched
    write_coef(REG_SPARE, COEF_W'(131071));
    send_sample(16'h4000);
    send_sample(16'hc000);
    drain();

    // strong feedback drives saturation both ways
    set_all_coefs(COEF_W'(131071));
    for (int i = 0; i < 3; i++) send_sample(16'h7fff);
    for (int i = 0; i < 2; i++) send_sample(16'h8000);
    for (int i = 0; i < 2; i++) send_sample(16'h0000);
    drain();

    set_all_coefs(COEF_W'(-131072));
    for (int i = 0; i < 3; i++) send_sample(16'h7fff);
    for (int i = 0; i < 2; i++) send_sample(16'h8000);
    for (int i = 0; i < 2; i++) send_sample(16'h0000);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      mix = coef_mix_t'(p % 3);
      for (int i = REG_B0; i <= REG_A3; i++) write_coef(i, pick_coef(mix));
      write_coef(REG_SPARE, COEF_W'($urandom()));
      settings_used++;
      if (p == RAND_PHASES - 1) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct = (p % 3 == 1) ? 0 : 25;
        sink_stall_pct = (p % 3 == 2) ? 0 : 25;
      end
      for (int i = 0; i < RAND_ITEMS; i++) send_sample(pick_sample());
      drain();
    end

    repeat (30) @(posedge clk);
    $display("%0d samples under %0d coefficient settings, random stalls on both streams",
             sb.samples_in, settings_used);
    $display("%0d outputs checked, %0d of them saturated", sb.outputs_seen, sb.clipped_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
